// File: rtl/ebam_pkg.sv
// Shared types and constants of the ellipse brush alpha mask.
// No dependencies; every other file of the block imports this package.
package ebam_pkg;

	localparam int COLOUR_W = 8;
	localparam int ALPHA_W = 8;
	localparam int PEN_W = 8;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_PEN_SIZE = 1'b0;

	localparam logic [PEN_W-1:0] PEN_SIZE_RESET = 8'd16;
	localparam int PEN_SIZE_MIN = 2;
	localparam int ALPHA_PEAK = 150;
	localparam int SQRT_SCALE = 22500;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_D2    = 8'b0000_0010,
		ST_RAD   = 8'b0000_0100,
		ST_SQRT  = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_ALPHA = 8'b0010_0000,
		ST_MUL   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

endpackage

// File: rtl/ebam_if.sv
// Valid/ready channel interfaces for brush pixels in and masked pixels out.
// Depends on ebam_pkg for the field widths.
interface ebam_in_if;
	import ebam_pkg::*;

	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] in_blue;
	logic [COLOUR_W-1:0] in_green;
	logic [COLOUR_W-1:0] in_red;

	modport source (output valid, output in_blue, output in_green, output in_red,
		input ready);
	modport sink (input valid, input in_blue, input in_green, input in_red,
		output ready);
endinterface

interface ebam_out_if;
	import ebam_pkg::*;

	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] out_blue;
	logic [COLOUR_W-1:0] out_green;
	logic [COLOUR_W-1:0] out_red;
	logic [ALPHA_W-1:0]  out_alpha;
	logic                last_pixel;

	modport source (output valid, output out_blue, output out_green, output out_red,
		output out_alpha, output last_pixel, input ready);
	modport sink (input valid, input out_blue, input out_green, input out_red,
		input out_alpha, input last_pixel, output ready);
endinterface

// File: rtl/ellipse_brush_alpha_mask.sv
// Top level of the ellipse brush alpha mask: counters, square root, divider, color scaling.
// Depends on ebam_pkg and on the channel interfaces in ebam_if.sv.
//
// Usage. The brush channel carries one pixel per beat (blue, green, red) in raster
// order, left to right and top to bottom. The block keeps the column and row itself
// and returns on the mask channel one beat per pixel: the colors scaled by the
// opacity, the opacity itself and a flag on the last pixel of the raster.
// The brush is pen_size rows high (at least 2) and pen_size/2 columns wide. pen_size sits at
// byte address 0 of the APB port; writing it restarts the raster at the top left.
// Write it only while no pixel is in flight.
//
// Sequence. A pixel is accepted only when the datapath is idle. It then forms the
// squared distance (ST_D2) and scales it (ST_RAD), takes one root bit per cycle in
// the two-bits-a-cycle square root (ST_SQRT), one quotient bit per cycle in the
// restoring divider by the radius (ST_DIV), and then forms the opacity (ST_ALPHA),
// the products (ST_MUL) and the divide by 255 (ST_OUT).
// The result sits in an output register, so a new pixel is accepted while a
// finished one waits; if the receiver stalls longer, the next result holds in the
// final stage and input stops.
// Reset sets pen_size to 16, clears both counters and empties the output register.
module ellipse_brush_alpha_mask #(
	parameter int MAX_PEN_SIZE = 255
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ebam_pkg::ADDR_W-1:0]  paddr,
	input  logic [ebam_pkg::DATA_W-1:0]  pwdata,
	output logic [ebam_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	ebam_in_if.sink                      brush,
	ebam_out_if.source                   mask
);
	import ebam_pkg::*;

	// Height needs SIZE_W bits; width, radius and both offsets need one bit less.
	localparam int SIZE_W = $clog2(MAX_PEN_SIZE + 1);
	localparam int HALF_W = SIZE_W - 1;
	localparam int CMP_W = (SIZE_W > PEN_W) ? SIZE_W : PEN_W;
	localparam int D2_W = 2 * HALF_W + 1;
	localparam int RAD_W = D2_W + 15;        // 22500 fits in 15 bits; RAD_W is even
	localparam int ROOT_W = RAD_W / 2;
	localparam int STEP_W = $clog2(ROOT_W);
	localparam int PROD_W = COLOUR_W + ALPHA_W;

	// Configuration register and raster counters.
	logic [PEN_W-1:0]  pen_size_q;
	logic [HALF_W-1:0] col_q;
	logic [SIZE_W-1:0] row_q;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	// Datapath registers.
	logic [HALF_W-1:0]   dx_q, dy_q;
	logic [D2_W-1:0]     d2_q;
	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W+1:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [HALF_W-1:0]   drem_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [COLOUR_W-1:0] blue_q, green_q, red_q;
	logic [PROD_W-1:0]   prod_b_q, prod_g_q, prod_r_q;
	logic                last_q;

	// Output register.
	logic                out_valid_q;
	logic [COLOUR_W-1:0] out_blue_q, out_green_q, out_red_q;
	logic [ALPHA_W-1:0]  out_alpha_q;
	logic                out_last_q;

	logic cfg_wr;
	logic in_beat;
	logic out_load;

	// Clamped brush geometry.
	logic [CMP_W-1:0]  h_cmp;
	logic [SIZE_W-1:0] h;
	logic [HALF_W-1:0] w;
	logic [HALF_W-1:0] x;
	logic [SIZE_W-1:0] y;
	logic [HALF_W:0]   x2;
	logic [HALF_W:0]   x_inc;
	logic [SIZE_W:0]   y_inc;
	logic [HALF_W:0]   dx_full;
	logic [SIZE_W-1:0] dy_full;
	logic [SIZE_W-1:0] y_mid;
	logic              last_now;

	logic [2*HALF_W-1:0] sq_x, sq_y;

	// Square root step.
	logic [ROOT_W+1:0] srem_sh;
	logic [ROOT_W+1:0] strial;
	logic              sbit;

	// Divider step.
	logic [HALF_W:0] drem_sh;
	logic            dbit;

	logic [PROD_W:0] sum_b, sum_g, sum_r;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1:2] == REG_PEN_SIZE);
	assign prdata = (paddr[ADDR_W-1:2] == REG_PEN_SIZE)
		? DATA_W'(pen_size_q) : '0;

	assign brush.ready = (state_q == ST_IDLE);
	assign in_beat = brush.valid && brush.ready;

	always_comb begin
		h_cmp = CMP_W'(pen_size_q);
		if (h_cmp < CMP_W'(PEN_SIZE_MIN)) begin
			h_cmp = CMP_W'(PEN_SIZE_MIN);
		end
		if (h_cmp > CMP_W'(MAX_PEN_SIZE)) begin
			h_cmp = CMP_W'(MAX_PEN_SIZE);
		end
	end

	assign h = h_cmp[SIZE_W-1:0];
	assign w = h[SIZE_W-1:1];
	assign y_mid = {1'b0, w};

	assign x = (col_q >= w) ? '0 : col_q;
	assign y = (row_q >= h) ? '0 : row_q;

	assign x2 = {x, 1'b0};
	assign dx_full = (x2 >= {1'b0, w}) ? (x2 - {1'b0, w}) : ({1'b0, w} - x2);
	assign dy_full = (y >= y_mid) ? (y - y_mid) : (y_mid - y);

	assign x_inc = {1'b0, x} + 1'b1;
	assign y_inc = {1'b0, y} + 1'b1;
	assign last_now = (x_inc == {1'b0, w}) && (y_inc == {1'b0, h});

	assign sq_x = dx_q * dx_q;
	assign sq_y = dy_q * dy_q;

	// Two radicand bits enter the partial remainder each cycle.
	assign srem_sh = {srem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
	assign strial = {root_q, 2'b01};
	assign sbit = (srem_sh >= strial);

	// One root bit enters the divider remainder each cycle; the quotient
	// shifts into the same register behind it.
	assign drem_sh = {drem_q, root_q[ROOT_W-1]};
	assign dbit = (drem_sh >= {1'b0, w});

	// Floor of p/255 for p below 65535: (p + p/256 + 1) / 256.
	assign sum_b = {1'b0, prod_b_q} + (PROD_W + 1)'(prod_b_q[PROD_W-1:8]) + 1'b1;
	assign sum_g = {1'b0, prod_g_q} + (PROD_W + 1)'(prod_g_q[PROD_W-1:8]) + 1'b1;
	assign sum_r = {1'b0, prod_r_q} + (PROD_W + 1)'(prod_r_q[PROD_W-1:8]) + 1'b1;

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || mask.ready);

	// Control: configuration, raster position, sequencer, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_size_q  <= PEN_SIZE_RESET;
			col_q       <= '0;
			row_q       <= '0;
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				pen_size_q <= pwdata[PEN_W-1:0];
				col_q      <= '0;
				row_q      <= '0;
			end else if (in_beat) begin
				if (x_inc >= {1'b0, w}) begin
					col_q <= '0;
					row_q <= (y_inc >= {1'b0, h}) ? '0 : y_inc[SIZE_W-1:0];
				end else begin
					col_q <= x_inc[HALF_W-1:0];
					row_q <= y;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_D2;
					end
				end
				ST_D2: state_q <= ST_RAD;
				ST_RAD: begin
					state_q <= ST_SQRT;
					step_q  <= '0;
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						state_q <= ST_ALPHA;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ALPHA: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (mask.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			blue_q  <= brush.in_blue;
			green_q <= brush.in_green;
			red_q   <= brush.in_red;
			dx_q    <= dx_full[HALF_W-1:0];
			dy_q    <= dy_full[HALF_W-1:0];
			last_q  <= last_now;
		end

		unique case (state_q)
			ST_D2: d2_q <= D2_W'(sq_x) + D2_W'(sq_y);
			ST_RAD: begin
				rad_q  <= RAD_W'(d2_q) * RAD_W'(SQRT_SCALE);
				srem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				srem_q <= sbit ? (srem_sh - strial) : srem_sh;
				root_q <= {root_q[ROOT_W-2:0], sbit};
				drem_q <= '0;
			end
			ST_DIV: begin
				drem_q <= dbit ? HALF_W'(drem_sh - {1'b0, w}) : drem_sh[HALF_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], dbit};
			end
			ST_ALPHA: begin
				// The divider leaves the quotient, the distance in 1/150 of the radius.
				alpha_q <= (root_q >= ROOT_W'(ALPHA_PEAK))
					? '0 : ALPHA_W'(ROOT_W'(ALPHA_PEAK) - root_q);
			end
			ST_MUL: begin
				prod_b_q <= blue_q * alpha_q;
				prod_g_q <= green_q * alpha_q;
				prod_r_q <= red_q * alpha_q;
			end
			ST_IDLE, ST_OUT: begin
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_blue_q  <= sum_b[15:8];
			out_green_q <= sum_g[15:8];
			out_red_q   <= sum_r[15:8];
			out_alpha_q <= alpha_q;
			out_last_q  <= last_q;
		end
	end

	assign mask.valid      = out_valid_q;
	assign mask.out_blue   = out_blue_q;
	assign mask.out_green  = out_green_q;
	assign mask.out_red    = out_red_q;
	assign mask.out_alpha  = out_alpha_q;
	assign mask.last_pixel = out_last_q;

	// A pixel flagged last wraps the raster back to the top left corner.
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && last_now && !cfg_wr) |=> (col_q == '0 && row_q == '0))
		else $error("raster did not wrap after the last pixel");

	// The divider remainder stays below the radius throughout the divide.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (drem_q < w))
		else $error("divider remainder reached the radius");

	// When the square root finishes, its remainder does not exceed twice the root.
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |-> (srem_q <= {1'b0, root_q, 1'b0}))
		else $error("square root remainder out of range");

	// A delivered opacity never exceeds its peak.
	a_alpha_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_alpha_q <= ALPHA_W'(ALPHA_PEAK)))
		else $error("opacity above peak");

	// An accepted pixel always starts the sequencer.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_D2))
		else $error("accepted pixel did not start the datapath");

endmodule
